@@ hdl/spq_pkg.sv @@
// Package for the strict-priority symbol queue.
// Holds the level count, status codes, level type and the symbol classifier.
// No dependencies.
`default_nettype none

package spq_pkg;

  // Number of priority levels, fixed by the symbol mapping
  localparam int NUM_LEVELS = 3;
  // Default entries per level
  localparam int SPQ_LEVEL_DEPTH = 16;
  localparam int LVL_W = 2;
  localparam int SYM_W = 8;

  typedef logic [LVL_W-1:0] level_t;
  typedef logic [SYM_W-1:0] sym_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  typedef struct packed {
    logic   ok;
    level_t lvl;
  } sym_class_t;

  localparam sym_t CH_A = 8'h41;
  localparam sym_t CH_B = 8'h42;
  localparam sym_t CH_C = 8'h43;
  localparam sym_t CH_D = 8'h44;
  localparam sym_t CH_E = 8'h45;
  localparam sym_t CH_F = 8'h46;
  localparam sym_t CH_G = 8'h47;
  localparam sym_t CH_LOWER_A = 8'h61;
  localparam sym_t CH_LOWER_Z = 8'h7A;
  localparam sym_t CASE_BIT   = 8'h20;

  // Map a symbol to its level, folding lower case onto upper case
  function automatic sym_class_t level_of(input sym_t sym);
    sym_t       up;
    sym_class_t cls;
    up = sym;
    if (sym >= CH_LOWER_A && sym <= CH_LOWER_Z) begin
      up = sym - CASE_BIT;
    end
    cls.ok  = 1'b1;
    cls.lvl = level_t'(0);
    unique case (up)
      CH_A, CH_G: begin
        cls.lvl = level_t'(0);
      end
      CH_B, CH_C: begin
        cls.lvl = level_t'(1);
      end
      CH_D, CH_E, CH_F: begin
        cls.lvl = level_t'(2);
      end
      default: begin
        cls.ok = 1'b0;
      end
    endcase
    return cls;
  endfunction

endpackage

`default_nettype wire

@@ hdl/spq_cmd_if.sv @@
// Command channel of the strict-priority symbol queue.
// Carries valid/ready, the operation bit and the symbol. No dependencies.
`default_nettype none

interface spq_cmd_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] symbol;

  modport source (output valid, func, symbol, input ready);
  modport sink   (input valid, func, symbol, output ready);
endinterface

`default_nettype wire

@@ hdl/spq_rsp_if.sv @@
// Response channel of the strict-priority symbol queue.
// Carries valid/ready and the result fields. Depends on spq_pkg.
`default_nettype none

interface spq_rsp_if import spq_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] out_symbol;
  level_t     out_level;
  status_t    status;

  modport source (output valid, out_symbol, out_level, status, input ready);
  modport sink   (input valid, out_symbol, out_level, status, output ready);
endinterface

`default_nettype wire

@@ hdl/strict_priority_char_queue.sv @@
// Top level of the strict-priority symbol queue: three FIFO levels in one
// slot memory. Depends on spq_pkg, spq_cmd_if and spq_rsp_if.
//
// Channel  Dir  Payload                        Handshake
// cmd      in   func, symbol                   valid/ready
// res      out  out_symbol, out_level, status  valid/ready
//
// One transaction per cycle while the result side keeps up: the command is
// classified and the slot memory written or read in the accept cycle, and the
// result (with the registered memory read data) is shown the cycle after.
// A result held by a stalled sink holds cmd.ready low until it is taken.
// Synchronous reset empties every level; the slot memory is not cleared.
`default_nettype none

module strict_priority_char_queue import spq_pkg::*; #(
  parameter int LEVEL_DEPTH = SPQ_LEVEL_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  spq_cmd_if.sink   cmd,
  spq_rsp_if.source res
);

  localparam int PW    = $clog2(LEVEL_DEPTH);
  localparam int FW    = $clog2(LEVEL_DEPTH + 1);
  localparam int SLOTS = NUM_LEVELS * LEVEL_DEPTH;
  localparam int AW    = $clog2(SLOTS);

  // Level pointers and fill counts
  logic [PW-1:0] head [NUM_LEVELS];
  logic [PW-1:0] tail [NUM_LEVELS];
  logic [FW-1:0] fill [NUM_LEVELS];

  // Slot memory, one region of LEVEL_DEPTH entries per level
  sym_t          slot_mem [SLOTS];
  sym_t          rd_data;

  // Output register
  logic          out_valid;
  level_t        out_lvl;
  status_t       out_status;
  logic          out_take;

  logic          accept;
  sym_class_t    cls;
  level_t        op_lvl;
  status_t       op_status;
  logic          do_enq;
  logic          do_deq;
  logic [PW-1:0] cur_head;
  logic [PW-1:0] cur_tail;
  logic [FW-1:0] cur_fill;
  logic [PW-1:0] head_adv;
  logic [PW-1:0] tail_adv;
  logic [AW-1:0] addr;

  assign accept    = cmd.valid && cmd.ready;
  assign cmd.ready = !out_valid || res.ready;
  assign cls       = level_of(cmd.symbol);

  // Pick the level the transaction works on, then decide its outcome
  always_comb begin
    op_lvl    = level_t'(0);
    op_status = ST_OK;
    do_enq    = 1'b0;
    do_deq    = 1'b0;
    if (!cmd.func) begin
      op_lvl = cls.lvl;
    end else begin
      priority if (fill[0] != '0) begin
        op_lvl = level_t'(0);
      end else if (fill[1] != '0) begin
        op_lvl = level_t'(1);
      end else begin
        op_lvl = level_t'(2);
      end
    end
    cur_head = head[op_lvl];
    cur_tail = tail[op_lvl];
    cur_fill = fill[op_lvl];
    if (!cmd.func) begin
      if (!cls.ok) begin
        op_status = ST_INVALID;
        op_lvl    = level_t'(0);
      end else if (cur_fill == FW'(LEVEL_DEPTH)) begin
        op_status = ST_FULL;
      end else begin
        do_enq = 1'b1;
      end
    end else begin
      if (cur_fill == '0) begin
        op_status = ST_EMPTY;
        op_lvl    = level_t'(0);
      end else begin
        do_deq = 1'b1;
      end
    end
  end

  // Pointer wrap and slot address
  always_comb begin
    head_adv = (cur_head == PW'(LEVEL_DEPTH - 1)) ? '0 : cur_head + 1'b1;
    tail_adv = (cur_tail == PW'(LEVEL_DEPTH - 1)) ? '0 : cur_tail + 1'b1;
    addr     = AW'(op_lvl) * AW'(LEVEL_DEPTH) + AW'(do_enq ? cur_tail : cur_head);
  end

  // Level state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        fill[i] <= '0;
      end
    end else if (accept) begin
      if (do_enq) begin
        tail[op_lvl] <= tail_adv;
        fill[op_lvl] <= cur_fill + 1'b1;
      end
      if (do_deq) begin
        fill[op_lvl] <= cur_fill - 1'b1;
        if (cur_fill == FW'(1)) begin
          head[op_lvl] <= '0;
          tail[op_lvl] <= '0;
        end else begin
          head[op_lvl] <= head_adv;
        end
      end
    end
  end

  // Slot memory: write on enqueue, registered read on dequeue
  always_ff @(posedge clk) begin
    if (accept && do_enq) begin
      slot_mem[addr] <= cmd.symbol;
    end
    if (accept && do_deq) begin
      rd_data <= slot_mem[addr];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_lvl    <= op_lvl;
      out_status <= op_status;
      out_take   <= do_deq;
    end
  end

  assign res.valid      = out_valid;
  assign res.out_level  = out_lvl;
  assign res.status     = out_status;
  assign res.out_symbol = out_take ? rd_data : '0;

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill[0] <= FW'(LEVEL_DEPTH) && fill[1] <= FW'(LEVEL_DEPTH)
      && fill[2] <= FW'(LEVEL_DEPTH))
    else $error("level fill above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (fill[0] != '0 || (head[0] == '0 && tail[0] == '0))
      && (fill[1] != '0 || (head[1] == '0 && tail[1] == '0))
      && (fill[2] != '0 || (head[2] == '0 && tail[2] == '0)))
    else $error("empty level with non-zero pointers");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> res.valid)
    else $error("accepted transaction gave no result");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status == ST_EMPTY)
      |-> (res.out_symbol == '0 && res.out_level == level_t'(0)))
    else $error("empty result carries data");

endmodule

`default_nettype wire

@@ dv/tb_strict_priority_char_queue.sv @@
// Self-checking testbench for strict_priority_char_queue: random and directed
// enqueue/dequeue traffic, checked against an in-bench priority queue model.
// Depends on spq_pkg, spq_cmd_if, spq_rsp_if and the queue top level.

module tb_strict_priority_char_queue import spq_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = SPQ_LEVEL_DEPTH;
  localparam int TOTAL_ITEMS  = 1550;
  localparam int CALM_ITEMS   = 150;
  localparam int LONG_HOLD    = 60;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic FN_ENQ = 1'b0;
  localparam logic FN_DEQ = 1'b1;

  typedef struct {
    logic fn;
    sym_t sym;
    bit   pause;
  } cmd_item_t;

  typedef struct {
    sym_t    sym;
    level_t  lvl;
    status_t st;
  } result_t;

  logic clk;
  logic rst;

  spq_cmd_if cmd_ch ();
  spq_rsp_if rsp_ch ();

  strict_priority_char_queue #(
    .LEVEL_DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(rsp_ch)
  );

  // Commands still to send, results still owed, and the level contents
  cmd_item_t cmd_backlog[$];
  result_t   due_results[$];
  sym_t      level_q[NUM_LEVELS][$];

  int  err_count;
  int  results_seen;
  int  cycle_count;
  int  snd_idle_pct;
  int  rcv_idle_pct;
  int  send_gap;
  int  rcv_gap;
  int  hold_left;
  int  holds_done;
  bit  calm;
  bit  pause_next;

  always #2 clk = ~clk;

  task automatic log_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  // Priority level of a symbol, -1 when the symbol is refused
  function automatic int symbol_level(input sym_t s);
    sym_t up;
    up = s;
    if (s >= CH_LOWER_A && s <= CH_LOWER_Z) begin
      up = s & ~CASE_BIT;
    end
    case (up)
      CH_A, CH_G:       return 0;
      CH_B, CH_C:       return 1;
      CH_D, CH_E, CH_F: return 2;
      default:          return -1;
    endcase
  endfunction

  // Apply one command to the level queues and return the result it owes
  function automatic result_t serve_command(input logic fn, input sym_t s);
    result_t r;
    int      lv;
    bit      taken;
    r.sym = '0;
    r.lvl = '0;
    r.st  = ST_OK;
    taken = 1'b0;
    if (fn == FN_ENQ) begin
      lv = symbol_level(s);
      if (lv < 0) begin
        r.st = ST_INVALID;
      end else if (level_q[lv].size() >= DEPTH) begin
        r.lvl = level_t'(lv);
        r.st  = ST_FULL;
      end else begin
        level_q[lv].push_back(s);
        r.lvl = level_t'(lv);
      end
    end else begin
      r.st = ST_EMPTY;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        if (!taken && level_q[l].size() != 0) begin
          r.sym = level_q[l].pop_front();
          r.lvl = level_t'(l);
          r.st  = ST_OK;
          taken = 1'b1;
        end
      end
    end
    return r;
  endfunction

  task automatic add_cmd(input logic fn, input sym_t s);
    cmd_item_t c;
    c.fn       = fn;
    c.sym      = s;
    c.pause    = pause_next;
    pause_next = 1'b0;
    cmd_backlog.push_back(c);
  endtask

  // A letter of the given level in random case; any level when lv < 0
  function automatic sym_t level_letter(input int lv);
    sym_t s;
    int   pick;
    pick = (lv < 0) ? $urandom_range(0, 2) : lv;
    case (pick)
      0: s = ($urandom_range(0, 1) != 0) ? CH_A : CH_G;
      1: s = ($urandom_range(0, 1) != 0) ? CH_B : CH_C;
      default: begin
        case ($urandom_range(0, 2))
          0:       s = CH_D;
          1:       s = CH_E;
          default: s = CH_F;
        endcase
      end
    endcase
    if ($urandom_range(0, 1) != 0) begin
      s = s | CASE_BIT;
    end
    return s;
  endfunction

  // Mostly valid letters, some arbitrary bytes
  function automatic sym_t enq_symbol(input int lv);
    if ($urandom_range(0, 99) < 8) begin
      return sym_t'($urandom_range(0, 255));
    end
    return level_letter(lv);
  endfunction

  task automatic build_random();
    int mode;
    int len;
    int lv;
    while (cmd_backlog.size() < TOTAL_ITEMS) begin
      mode = $urandom_range(0, 9);
      len  = $urandom_range(8, 40);
      if ($urandom_range(0, 29) == 0) begin
        pause_next = 1'b1;
      end
      case (mode)
        // mostly enqueues, to build up the levels
        0, 1, 2: begin
          repeat (len) begin
            if ($urandom_range(0, 99) < 80) add_cmd(FN_ENQ, enq_symbol(-1));
            else add_cmd(FN_DEQ, sym_t'($urandom_range(0, 255)));
          end
        end
        // mostly dequeues, runs levels empty
        3, 4, 5: begin
          repeat (len) begin
            if ($urandom_range(0, 99) < 80) add_cmd(FN_DEQ, sym_t'($urandom_range(0, 255)));
            else add_cmd(FN_ENQ, enq_symbol(-1));
          end
        end
        6, 7: begin
          repeat (len) begin
            if ($urandom_range(0, 1) != 0) add_cmd(FN_DEQ, sym_t'($urandom_range(0, 255)));
            else add_cmd(FN_ENQ, enq_symbol(-1));
          end
        end
        // one level filled up to or past full, then partly drained
        8: begin
          lv = $urandom_range(0, NUM_LEVELS - 1);
          repeat ($urandom_range(14, 20)) add_cmd(FN_ENQ, level_letter(lv));
          repeat ($urandom_range(2, 10)) add_cmd(FN_DEQ, sym_t'($urandom_range(0, 255)));
        end
        // noise: any operation, any byte
        default: begin
          repeat ($urandom_range(5, 15)) begin
            add_cmd(logic'($urandom_range(0, 1)), sym_t'($urandom_range(0, 255)));
          end
        end
      endcase
    end
  endtask

  // Clock count, timeout and idling intensity for both sides
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 100 == 0) begin
      case ($urandom_range(0, 3))
        0:       snd_idle_pct <= 0;
        1:       snd_idle_pct <= 10;
        2:       snd_idle_pct <= 30;
        default: snd_idle_pct <= 60;
      endcase
      case ($urandom_range(0, 3))
        0:       rcv_idle_pct <= 0;
        1:       rcv_idle_pct <= 10;
        2:       rcv_idle_pct <= 30;
        default: rcv_idle_pct <= 60;
      endcase
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_strict_priority_char_queue: FAIL");
      $finish;
    end
  end

  // Command driver: predicts on each accepted transaction, then offers the next
  always @(posedge clk) begin
    cmd_item_t nxt;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      send_gap     <= 0;
      calm         <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        due_results.push_back(serve_command(cmd_ch.func, cmd_ch.symbol));
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (send_gap != 0) begin
          send_gap     <= send_gap - 1;
          cmd_ch.valid <= 1'b0;
        end else if (cmd_backlog.size() == 0 ||
                     (cmd_backlog[0].pause && due_results.size() != 0)) begin
          cmd_ch.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < snd_idle_pct) begin
          send_gap     <= $urandom_range(0, 13);
          cmd_ch.valid <= 1'b0;
        end else begin
          nxt           = cmd_backlog.pop_front();
          cmd_ch.valid  <= 1'b1;
          cmd_ch.func   <= nxt.fn;
          cmd_ch.symbol <= nxt.sym;
        end
      end
      calm <= (cmd_backlog.size() < CALM_ITEMS);
    end
  end

  // Long receiver hold-off, so the block backs up and stalls its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && results_seen >= 400 * (holds_done + 1)) begin
      hold_left  <= LONG_HOLD;
      holds_done <= holds_done + 1;
    end
  end

  // Result monitor: checks each transaction against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    logic    rdy;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rcv_gap      <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen <= results_seen + 1;
        if (due_results.size() == 0) begin
          log_mismatch($sformatf("result %0d arrived with nothing outstanding", results_seen));
        end else begin
          want = due_results.pop_front();
          if (rsp_ch.out_symbol !== want.sym) begin
            log_mismatch($sformatf("result %0d out_symbol %0h, expected %0h",
                                   results_seen, rsp_ch.out_symbol, want.sym));
          end
          if (rsp_ch.out_level !== want.lvl) begin
            log_mismatch($sformatf("result %0d out_level %0d, expected %0d",
                                   results_seen, rsp_ch.out_level, want.lvl));
          end
          if (rsp_ch.status !== want.st) begin
            log_mismatch($sformatf("result %0d status %0d, expected %s",
                                   results_seen, rsp_ch.status, want.st.name()));
          end
        end
      end
      if (hold_left != 0) begin
        rdy = 1'b0;
      end else if (rcv_gap != 0) begin
        rcv_gap <= rcv_gap - 1;
        rdy = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < rcv_idle_pct) begin
        rcv_gap <= $urandom_range(0, 13);
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      rsp_ch.ready <= rdy;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    cmd_ch.valid  = 1'b0;
    cmd_ch.func   = FN_ENQ;
    cmd_ch.symbol = '0;
    rsp_ch.ready  = 1'b0;
    err_count     = 0;
    results_seen  = 0;
    cycle_count   = 0;
    snd_idle_pct  = 0;
    rcv_idle_pct  = 0;
    pause_next    = 1'b0;

    // directed: empty dequeue, refused symbols, one letter of each kind, drain
    add_cmd(FN_DEQ, 8'hFF);
    add_cmd(FN_ENQ, 8'h00);
    add_cmd(FN_ENQ, 8'hFF);
    add_cmd(FN_ENQ, 8'h40);
    add_cmd(FN_ENQ, 8'h48);
    add_cmd(FN_ENQ, 8'h7A);
    add_cmd(FN_ENQ, CH_A | 8'h80);
    add_cmd(FN_ENQ, CH_D);
    add_cmd(FN_ENQ, CH_E | CASE_BIT);
    add_cmd(FN_ENQ, CH_B | CASE_BIT);
    add_cmd(FN_ENQ, CH_G);
    add_cmd(FN_ENQ, CH_A | CASE_BIT);
    add_cmd(FN_ENQ, CH_C);
    add_cmd(FN_ENQ, CH_F | CASE_BIT);
    repeat (7) add_cmd(FN_DEQ, 8'h00);
    add_cmd(FN_DEQ, 8'hAA);

    // sender waits for every result before the random part starts
    pause_next = 1'b1;
    build_random();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() != 0 || cmd_ch.valid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("tb_strict_priority_char_queue: PASS");
    end else begin
      $display("tb_strict_priority_char_queue: FAIL");
    end
    $finish;
  end

endmodule
